[rtl/multi_zone_range_presence_filter_unit_defines.svh]
// Assertion macros shared by the presence filter RTL.
`ifndef MULTI_ZONE_RANGE_PRESENCE_FILTER_UNIT_DEFINES_SVH
`define MULTI_ZONE_RANGE_PRESENCE_FILTER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MZRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define MZRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/mzrp_pkg.sv]
package mzrp_pkg;

  // Field and register widths
  localparam int DIST_W    = 16;
  localparam int MASK_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int PERSIST_W = 8;
  localparam int ACTIVE_W  = 3;

  typedef logic [DIST_W-1:0]    dist_t;
  typedef logic [MASK_W-1:0]    mask_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [PERSIST_W-1:0] persist_t;
  typedef logic [ACTIVE_W-1:0]  active_t;

  // Register indexes
  localparam cfg_idx_t REG_ZONE0_BOUNDS = 3'd0;
  localparam cfg_idx_t REG_ZONE1_BOUNDS = 3'd1;
  localparam cfg_idx_t REG_ZONE2_BOUNDS = 3'd2;
  localparam cfg_idx_t REG_ZONE3_BOUNDS = 3'd3;
  localparam cfg_idx_t REG_PERSISTENCE  = 3'd4;
  localparam cfg_idx_t REG_ACTIVE_ZONES = 3'd5;

  // Reset values
  localparam persist_t PERSIST_RESET = 8'd1;

endpackage

[rtl/multi_zone_range_presence_filter_unit.sv]
// Multi-zone range presence filter.
// Input channel: in_valid / in_stall carry one sample_distance per transaction.
// Output channel: out_valid / out_stall carry one result transaction per sample:
// enter_mask, exit_mask, present_mask and echo_distance (the sample when any
// zone entered, else zero).
// Config port: cfg_we writes cfg_data into register cfg_index at the clock edge;
// indexes 0..3 are zone windows (max in 31:16, min in 15:0), 4 is persistence,
// 5 is the active zone count. Write only while no transaction is in flight.
// Path: an accepted sample lands in the input register, then moves on to the
// result register, where its result is offered; one sample per cycle unless
// out_stall holds the result register. Per-zone window compares and run counter
// updates all sit in one combinational stage between the two registers.
// Stall: while out_stall holds a full result register, the input register still
// takes one transaction if empty, then holds and in_stall rises; nothing is
// dropped or repeated.
// Reset (rst, synchronous, active high): both stages empty, run counters and
// present flags cleared, windows 0, persistence 1, no zones active.
`include "multi_zone_range_presence_filter_unit_defines.svh"

module multi_zone_range_presence_filter_unit #(
  parameter int ZONES     = 4,
  parameter int RUN_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // Config write port
  input  logic                  cfg_we,
  input  mzrp_pkg::cfg_idx_t    cfg_index,
  input  mzrp_pkg::cfg_data_t   cfg_data,
  // Sample channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mzrp_pkg::dist_t       sample_distance,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output mzrp_pkg::mask_t       enter_mask,
  output mzrp_pkg::mask_t       exit_mask,
  output mzrp_pkg::mask_t       present_mask,
  output mzrp_pkg::dist_t       echo_distance
);
  import mzrp_pkg::*;

  localparam int CMP_W = (RUN_WIDTH > PERSIST_W) ? RUN_WIDTH : PERSIST_W;
  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  typedef logic [RUN_WIDTH-1:0] run_t;

  // Configuration registers
  cfg_data_t zone_bounds [ZONES];
  persist_t  persistence;
  active_t   active_zones;

  // Zone state
  run_t       inside_run  [ZONES];
  run_t       outside_run [ZONES];
  logic [ZONES-1:0] present_flag;

  // Input stage
  logic  s1_valid;
  dist_t s1_distance;

  // Next values from the update logic
  run_t       inside_run_next  [ZONES];
  run_t       outside_run_next [ZONES];
  logic [ZONES-1:0] present_flag_next;
  logic [ZONES-1:0] enter_next;
  logic [ZONES-1:0] exit_next;

  logic advance;
  logic in_accept;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int z = 0; z < ZONES; z++) begin
        zone_bounds[z] <= '0;
      end
      persistence  <= PERSIST_RESET;
      active_zones <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERSISTENCE:  persistence  <= cfg_data[PERSIST_W-1:0];
        REG_ACTIVE_ZONES: active_zones <= cfg_data[ACTIVE_W-1:0];
        default: begin
          for (int z = 0; z < ZONES; z++) begin
            if (cfg_index == CFG_IDX_W'(z)) begin
              zone_bounds[z] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  // Capture the sample into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_distance <= sample_distance;
    end
  end

  // Window compare and run counter update per zone
  always_comb begin
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    logic              in_win;
    logic              active;
    logic              hit;
    for (int z = 0; z < ZONES; z++) begin
      lo     = zone_bounds[z][DIST_W-1:0];
      hi     = zone_bounds[z][2*DIST_W-1:DIST_W];
      in_win = (s1_distance >= lo) && (s1_distance <= hi);
      active = (ACTIVE_W'(z) < active_zones);
      if (in_win) begin
        inside_run_next[z]  = (inside_run[z] == RUN_MAX) ? RUN_MAX
                                                         : inside_run[z] + 1'b1;
        outside_run_next[z] = '0;
        hit = CMP_W'(inside_run_next[z]) >= CMP_W'(persistence);
      end else begin
        outside_run_next[z] = (outside_run[z] == RUN_MAX) ? RUN_MAX
                                                          : outside_run[z] + 1'b1;
        inside_run_next[z]  = '0;
        hit = CMP_W'(outside_run_next[z]) >= CMP_W'(persistence);
      end
      enter_next[z] = active && in_win && hit && !present_flag[z];
      exit_next[z]  = active && !in_win && hit && present_flag[z];
      present_flag_next[z] = active && (enter_next[z] ||
                                        (present_flag[z] && !exit_next[z]));
      // Hold inactive zones at zero so they start fresh
      if (!active) begin
        inside_run_next[z]  = '0;
        outside_run_next[z] = '0;
      end
    end
  end

  // Commit zone state when the sample moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int z = 0; z < ZONES; z++) begin
        inside_run[z]  <= '0;
        outside_run[z] <= '0;
      end
      present_flag <= '0;
    end else if (s1_valid && advance) begin
      for (int z = 0; z < ZONES; z++) begin
        inside_run[z]  <= inside_run_next[z];
        outside_run[z] <= outside_run_next[z];
      end
      present_flag <= present_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      enter_mask    <= MASK_W'(enter_next);
      exit_mask     <= MASK_W'(exit_next);
      present_mask  <= MASK_W'(present_flag_next);
      echo_distance <= (|enter_next) ? s1_distance : '0;
    end
  end

  // Assertions
  `MZRP_ASSERT(a_enter_exit_disjoint, out_valid |-> ((enter_mask & exit_mask) == '0), "zone both entered and exited")
  `MZRP_ASSERT(a_events_match_presence, out_valid |-> (((enter_mask & ~present_mask) == '0) && ((exit_mask & present_mask) == '0)), "event disagrees with present flag")
  `MZRP_ASSERT(a_echo_only_on_enter, (out_valid && (enter_mask == '0)) |-> (echo_distance == '0), "echo distance without enter event")
  `MZRP_ASSERT(a_unused_bits_zero, out_valid |-> ((present_mask >> ZONES) == '0), "mask bit set above zone count")
  `MZRP_ASSERT_ALWAYS(a_reset_empties, rst |=> (!out_valid && !s1_valid), "pipeline not empty after reset")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import mzrp_pkg::*;

  localparam int ZONES = 4;
  localparam int RUN_W = 8;
  localparam int MAX_REPORTS = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  // Indexes past the last register; writes there must be ignored
  localparam cfg_idx_t REG_SPARE_A = 3'd6;
  localparam cfg_idx_t REG_SPARE_B = 3'd7;

  typedef struct packed {
    mask_t enter;
    mask_t leave;
    mask_t present;
    dist_t echo;
  } zone_result_t;

  // Presence predictor plus the queue of results it still waits for
  class presence_scoreboard;
    cfg_data_t bounds [ZONES];
    persist_t persist;
    active_t active;
    logic [RUN_W-1:0] inside_run [ZONES];
    logic [RUN_W-1:0] outside_run [ZONES];
    bit present [ZONES];
    zone_result_t expected_q [$];
    int mismatches;

    function new();
      foreach (bounds[z]) begin
        bounds[z] = '0;
        inside_run[z] = '0;
        outside_run[z] = '0;
        present[z] = 1'b0;
      end
      persist = PERSIST_RESET;
      active = '0;
      mismatches = 0;
    endfunction

    function void write_register(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        REG_ZONE0_BOUNDS: bounds[0] = data;
        REG_ZONE1_BOUNDS: bounds[1] = data;
        REG_ZONE2_BOUNDS: bounds[2] = data;
        REG_ZONE3_BOUNDS: bounds[3] = data;
        REG_PERSISTENCE:  persist = data[PERSIST_W-1:0];
        REG_ACTIVE_ZONES: active = data[ACTIVE_W-1:0];
        default: ;
      endcase
    endfunction

    // Saturate instead of wrapping
    function logic [RUN_W-1:0] run_step(logic [RUN_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(dist_t d);
      int in_use;
      dist_t lo, hi;
      zone_result_t r;
      in_use = (active > ZONES) ? ZONES : int'(active);
      r = '0;
      for (int z = 0; z < ZONES; z++) begin
        lo = bounds[z][15:0];
        hi = bounds[z][31:16];
        if (z >= in_use) begin
          // Hold unused zones cleared so they start fresh
          inside_run[z] = '0;
          outside_run[z] = '0;
          present[z] = 1'b0;
        end else if (d >= lo && d <= hi) begin
          inside_run[z] = run_step(inside_run[z]);
          outside_run[z] = '0;
          if (inside_run[z] >= persist && !present[z]) begin
            present[z] = 1'b1;
            r.enter[z] = 1'b1;
          end
        end else begin
          outside_run[z] = run_step(outside_run[z]);
          inside_run[z] = '0;
          if (outside_run[z] >= persist && present[z]) begin
            present[z] = 1'b0;
            r.leave[z] = 1'b1;
          end
        end
        if (present[z]) r.present[z] = 1'b1;
      end
      if (r.enter != '0) r.echo = d;
      expected_q.push_back(r);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", what);
    endfunction

    function void check_result(mask_t enter, mask_t leave, mask_t present_bits, dist_t echo);
      zone_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no sample pending: enter=%h exit=%h present=%h echo=%h",
                         enter, leave, present_bits, echo));
        return;
      end
      want = expected_q.pop_front();
      if (want.enter !== enter || want.leave !== leave ||
          want.present !== present_bits || want.echo !== echo)
        report($sformatf({"expected enter=%h exit=%h present=%h echo=%h, ",
                          "got enter=%h exit=%h present=%h echo=%h"},
                         want.enter, want.leave, want.present, want.echo,
                         enter, leave, present_bits, echo));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = '0;
  cfg_data_t cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  dist_t sample_distance = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mask_t enter_mask, exit_mask, present_mask;
  dist_t echo_distance;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  presence_scoreboard sb = new();

  always #10 clk = ~clk;

  multi_zone_range_presence_filter_unit #(
    .ZONES(ZONES),
    .RUN_WIDTH(RUN_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_distance(sample_distance),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .enter_mask(enter_mask),
    .exit_mask(exit_mask),
    .present_mask(present_mask),
    .echo_distance(echo_distance)
  );

  // Random backpressure on the result channel
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Note accepted samples, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_sample(sample_distance);
      if (out_valid && !out_stall)
        sb.check_result(enter_mask, exit_mask, present_mask, echo_distance);
    end
  end

  // Hard stop for a hung block
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive one sample transaction; called and returns at a falling edge
  task automatic send_sample(input dist_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_distance <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_register(idx, data);
    @(negedge clk);
  endtask

  // Rewrite every register once the block is idle; unused data bits get noise
  task automatic configure(cfg_data_t z0, cfg_data_t z1, cfg_data_t z2, cfg_data_t z3,
                           persist_t p, active_t a);
    cfg_data_t pdata, adata;
    pdata = $urandom;
    pdata[PERSIST_W-1:0] = p;
    adata = $urandom;
    adata[ACTIVE_W-1:0] = a;
    wait_drained();
    write_reg(REG_ZONE0_BOUNDS, z0);
    write_reg(REG_ZONE1_BOUNDS, z1);
    write_reg(REG_ZONE2_BOUNDS, z2);
    write_reg(REG_ZONE3_BOUNDS, z3);
    write_reg(REG_PERSISTENCE, pdata);
    write_reg(REG_ACTIVE_ZONES, adata);
    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    cfg_we <= 1'b0;
  endtask

  // Mostly narrow windows so samples land near them; some empty or wide open
  function automatic cfg_data_t random_window();
    dist_t lo, hi;
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        hi = dist_t'($urandom_range(3000));
        lo = dist_t'(hi + $urandom_range(500, 1));
        return {hi, lo};
      end
      default: begin
        lo = dist_t'($urandom_range(3000));
        hi = dist_t'(lo + $urandom_range(2000));
        return {hi, lo};
      end
    endcase
  endfunction

  // Aim at a window edge, just past it, inside it, or anywhere
  function automatic dist_t pick_distance();
    int z;
    dist_t lo, hi;
    z = $urandom_range(ZONES - 1);
    lo = sb.bounds[z][15:0];
    hi = sb.bounds[z][31:16];
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      2: return lo - 1'b1;
      3: return hi + 1'b1;
      4: return (lo <= hi) ? dist_t'($urandom_range(hi, lo)) : lo;
      default: return dist_t'($urandom);
    endcase
  endfunction

  // Runs of one distance long enough to cross the persistence count, plus noise
  task automatic random_phase(int n_items);
    int sent;
    int run_len;
    dist_t d;
    persist_t p;
    active_t a;
    p = ($urandom_range(7) == 0) ? persist_t'(0) : persist_t'($urandom_range(6, 1));
    a = ($urandom_range(2) == 0) ? active_t'($urandom_range(7)) : active_t'(ZONES);
    configure(random_window(), random_window(), random_window(), random_window(), p, a);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(39) == 0) wait_drained();
      d = pick_distance();
      if ($urandom_range(4) == 0) run_len = 1;
      else run_len = $urandom_range(int'(sb.persist) + 2, 1);
      repeat (run_len) begin
        send_sample(d);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Out of reset no zone is active
    send_sample(16'd0);
    send_sample(16'hFFFF);

    // Inclusive bounds, full-range, empty and single-point windows; count clamped
    configure({16'd200, 16'd100}, {16'hFFFF, 16'd0}, {16'd400, 16'd500},
              {16'hFFFF, 16'hFFFF}, 8'd1, 3'd7);
    send_sample(16'd99);
    send_sample(16'd100);
    send_sample(16'd200);
    send_sample(16'd201);
    send_sample(16'hFFFF);
    send_sample(16'd150);
    send_sample(16'd450);
    send_sample(16'd500);

    // Zero persistence acts like one; dropped zones clear
    configure({16'd200, 16'd100}, {16'hFFFF, 16'd0}, {16'd400, 16'd500},
              {16'hFFFF, 16'hFFFF}, 8'd0, 3'd2);
    send_sample(16'd50);
    send_sample(16'd150);
    send_sample(16'd50);

    // Persistence of three; re-enabled zones start fresh
    configure({16'd200, 16'd100}, {16'hFFFF, 16'd0}, {16'd400, 16'd500},
              {16'hFFFF, 16'hFFFF}, 8'd3, 3'd4);
    repeat (4) send_sample(16'd150);
    repeat (3) send_sample(16'd300);
    send_sample(16'd150);

    // Longest persistence: runs saturate, then enter and later exit
    send_idle_pct = 34;
    recv_stall_pct = 34;
    configure({16'hFFFF, 16'h0000}, '0, '0, '0, 8'hFF, 3'd1);
    repeat (270) send_sample(dist_t'($urandom));
    configure({16'h0000, 16'hFFFF}, '0, '0, '0, 8'hFF, 3'd1);
    repeat (270) send_sample(dist_t'($urandom));

    // Random phases rotating through idle and stall mixes
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      random_phase(105);
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
